### rtl/fptu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and coefficient table of the four-point transform unit.
package fptu_pkg;

    typedef enum logic [1:0] {
        CMD_FDCT = 2'd0,
        CMD_IDCT = 2'd1,
        CMD_FDST = 2'd2,
        CMD_IDST = 2'd3
    } t_cmd;

    typedef logic signed [7:0]  t_coef;
    typedef logic signed [17:0] t_term;
    typedef logic signed [25:0] t_prod;
    typedef logic signed [27:0] t_sum;

    localparam int PIPE_DEPTH = 4;           // stages from input beat to output register
    localparam logic [3:0] SHIFT_RESET = 4'd7;
    localparam logic [2:0] ADDR_SHIFT  = 3'd0;
    localparam logic signed [28:0] SAT_MAX = 29'sd32767;
    localparam logic signed [28:0] SAT_MIN = -29'sd32768;

    // COEF[cmd][output][term]; terms are formed per command in the pre-add stage
    localparam t_coef COEF [4][4][3] = '{
        '{ '{8'sd64,  8'sd64,  8'sd0},   // forward DCT
           '{8'sd83,  8'sd36,  8'sd0},
           '{8'sd64, -8'sd64,  8'sd0},
           '{8'sd36, -8'sd83,  8'sd0} },
        '{ '{8'sd64,  8'sd83,  8'sd36},  // inverse DCT
           '{8'sd64,  8'sd36, -8'sd83},
           '{8'sd64, -8'sd36,  8'sd83},
           '{8'sd64, -8'sd83, -8'sd36} },
        '{ '{8'sd29,  8'sd55,  8'sd74},  // forward DST
           '{8'sd74,  8'sd0,   8'sd0},
           '{8'sd29,  8'sd55, -8'sd74},
           '{8'sd55, -8'sd29,  8'sd74} },
        '{ '{8'sd29,  8'sd55,  8'sd74},  // inverse DST
           '{8'sd55, -8'sd29,  8'sd74},
           '{8'sd74,  8'sd0,   8'sd0},
           '{8'sd55,  8'sd29, -8'sd74} }
    };

endpackage

### rtl/four_point_transform_unit.sv
`timescale 1ns / 1ps
// Top level: four-point integer DCT/DST pipeline with APB shift register.
//
//  Channel   | Direction | Signals                                   | Beat
//  ----------+-----------+-------------------------------------------+--------------------------
//  s_axis    | in        | tvalid, tready, tdata[63:0], tuser[1:0]   | one 4-element vector
//  m_axis    | out       | tvalid, tready, tdata[63:0]               | one transformed vector
//  APB       | in/out    | psel, penable, pwrite, paddr[2:0], pwdata | shift_amount at 0x0
//
//  One beat is accepted per cycle while s_axis_tready is high. Four register stages
//  (pre-add, multiply, sum, round/shift/wrap or clamp into the output): a beat passes
//  through the pre-add, multiply and sum registers into the output register.
//  The four stages hold one beat each; a stall on m_axis backs up stage by stage,
//  so s_axis_tready drops only when every stage is full.
//  Reset (synchronous, i_rst_n low) empties the pipeline and sets shift_amount to 7.
//  shift_amount is sampled in the last stage; write it only while the pipe is empty.
module four_point_transform_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input vector
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // in0[15:0], in1[31:16], in2[47:32], in3[63:48]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    // result vector
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out0[15:0], out1[31:16], out2[47:32], out3[63:48]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fptu_pkg::*;

    // ---------------- configuration ----------------
    logic [3:0] r_shift;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_SHIFT) begin
            r_shift <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_SHIFT) begin
            prdata = {28'd0, r_shift};
        end
    end

    // ---------------- stage enables ----------------
    // A stage loads when it is empty or its content moves on this cycle.
    logic r_v1, r_v2, r_v3, r_vo;
    logic en1, en2, en3, eno;

    assign eno           = !r_vo || m_axis_tready;
    assign en3           = !r_v3 || eno;
    assign en2           = !r_v2 || en3;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1;

    // ---------------- stage 1: pre-add ----------------
    // Each output is a sum of three coefficient * term products; the terms
    // are the butterfly sums and differences of the chosen transform.
    t_cmd  cmd_in;
    t_term x0, x1, x2, x3;
    t_term n_t [4][3];
    t_term r_t1 [4][3];
    t_cmd  r_cmd1;

    assign cmd_in = t_cmd'(s_axis_tuser);
    assign x0 = 18'(signed'(s_axis_tdata[15:0]));
    assign x1 = 18'(signed'(s_axis_tdata[31:16]));
    assign x2 = 18'(signed'(s_axis_tdata[47:32]));
    assign x3 = 18'(signed'(s_axis_tdata[63:48]));

    always_comb begin
        n_t = '{default: '{default: '0}};
        case (cmd_in)
            CMD_FDCT: begin
                n_t[0] = '{x0 + x3, x1 + x2, '0};
                n_t[1] = '{x0 - x3, x1 - x2, '0};
                n_t[2] = '{x0 + x3, x1 + x2, '0};
                n_t[3] = '{x0 - x3, x1 - x2, '0};
            end
            CMD_IDCT: begin
                n_t[0] = '{x0 + x2, x1, x3};
                n_t[1] = '{x0 - x2, x1, x3};
                n_t[2] = '{x0 - x2, x1, x3};
                n_t[3] = '{x0 + x2, x1, x3};
            end
            CMD_FDST: begin
                n_t[0] = '{x0 + x3, x1 + x3, x2};
                n_t[1] = '{x0 + x1 - x3, '0, '0};
                n_t[2] = '{x0 - x1, x0 + x3, x2};
                n_t[3] = '{x0 - x1, x1 + x3, x2};
            end
            CMD_IDST: begin
                n_t[0] = '{x0 + x2, x2 + x3, x1};
                n_t[1] = '{x0 - x3, x2 + x3, x1};
                n_t[2] = '{x0 - x2 + x3, '0, '0};
                n_t[3] = '{x0 + x2, x0 - x3, x1};
            end
            default: begin
                n_t = '{default: '{default: '0}};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_t1   <= n_t;
            r_cmd1 <= cmd_in;
        end
    end

    // ---------------- stage 2: constant multiplies ----------------
    t_prod r_p2 [4][3];
    logic  r_inv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p2[k][j] <= 26'(r_t1[k][j]) * 26'(COEF[r_cmd1][k][j]);
                end
            end
            r_inv2 <= r_cmd1[0];   // inverse transforms saturate
        end
    end

    // ---------------- stage 3: product sums ----------------
    t_sum r_s3 [4];
    logic r_inv3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int k = 0; k < 4; k++) begin
                r_s3[k] <= 28'(r_p2[k][0]) + 28'(r_p2[k][1]) + 28'(r_p2[k][2]);
            end
            r_inv3 <= r_inv2;
        end
    end

    // ---------------- stage 4: round, shift, wrap or clamp ----------------
    // round = 1 << (shift-1), zero when shift is zero
    logic [28:0]        rnd;
    logic signed [28:0] scaled [4];
    logic [15:0]        n_out  [4];
    logic [63:0]        r_out;

    assign rnd = (29'd1 << r_shift) >> 1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            scaled[k] = (29'(r_s3[k]) + signed'(rnd)) >>> r_shift;
            if (r_inv3 && scaled[k] > SAT_MAX) begin
                n_out[k] = SAT_MAX[15:0];
            end else if (r_inv3 && scaled[k] < SAT_MIN) begin
                n_out[k] = SAT_MIN[15:0];
            end else begin
                n_out[k] = scaled[k][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (eno) begin
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eno) begin
            r_out <= {n_out[3], n_out[2], n_out[1], n_out[0]};
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_out;

endmodule

### rtl/fptu_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the four-point transform unit, bound to the top level.
module fptu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        pready
);
    import fptu_pkg::*;

    // beats accepted but not yet delivered
    logic [2:0] r_inflight;
    logic [2:0] n_inflight;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_inflight = r_inflight;
        if (in_beat && !out_beat) begin
            n_inflight = r_inflight + 3'd1;
        end else if (out_beat && !in_beat) begin
            n_inflight = r_inflight - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_inflight != 3'd0)
        else $error("output beat without a pending input beat");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'(PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

    a_accept_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_apb_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind four_point_transform_unit fptu_checker u_fptu_checker (.*);
